// File: rtl/popht_pkg.sv
package popht_pkg;

	// Register indexes of the configuration port
	localparam logic [2:0] REG_STRENGTH = 3'd0;
	localparam logic [2:0] REG_CELL_W   = 3'd1;
	localparam logic [2:0] REG_RADIUS   = 3'd2;
	localparam logic [2:0] REG_ROWS     = 3'd3;
	localparam logic [2:0] REG_COLS     = 3'd4;

	// Colour map weights per channel (blue, green, red): bias, kb, kg, kr, 12 fraction bits
	localparam logic signed [16:0] COEF [3][4] = '{
		'{ 17'sd2393,   -17'sd1005, -17'sd15632, -17'sd4327 },
		'{ -17'sd25062, -17'sd4138,  17'sd46600,  17'sd11466 },
		'{ -17'sd13314,  17'sd5483,  17'sd42756,  17'sd5829 }
	};

	// Halftone dot colour, blue / green / red
	localparam logic [7:0] DOT_COLOUR [3] = '{ 8'd157, 8'd30, 8'd200 };

	// Clamp limit of the colour sum: 8 * 255 * 4096
	localparam int SUM_LIMIT = 8355840;

	// ceil(2^28 / 255): exact quotient by 255 for inputs below about 2^20
	localparam logic [20:0] RECIP_255 = 21'd1052689;
	localparam int RECIP_SHIFT = 28;

	// floor(x / 255) for x up to 255 * 255
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = 17'(x) + 17'(x >> 8) + 17'd1;
		return t[15:8];
	endfunction

	// Three restoring steps of a remainder by w, most significant bit first
	function automatic logic [9:0] rem_step3(input logic [9:0] r, input logic [2:0] bits,
			input logic [9:0] w);
		logic [10:0] t;
		logic [9:0] acc;
		acc = r;
		for (int k = 2; k >= 0; k--) begin
			t = {acc, bits[k]};
			if (t >= {1'b0, w})
				t = t - {1'b0, w};
			acc = t[9:0];
		end
		return acc;
	endfunction

endpackage

// File: rtl/popart_halftone_pixel_filter.sv
// Pop-art halftone pixel filter. Each beat on the slave side carries one BGR pixel with its row and
// column; each beat on the master side carries the filtered pixel, in the same order. Every channel
// is colour-mapped through a fixed weighted sum of the three channels, a sigmoid ROM and a blend
// with the original at alpha 255 minus effect_strength; pixels of full grid cells that fall within
// circle_radius of their cell centre are then blended toward purple. The block takes one pixel per
// clock while the output is not stalled; the pipeline has eight stages, whose longest part is the
// cell remainder, worked out three bits per stage over four stages. A stalled output holds the
// pipeline back only as far as it is full. Write configuration only when no pixel is in flight.
module popart_halftone_pixel_filter
	import popht_pkg::*;
#(
	parameter int MAX_DIMENSION       = 4096,
	parameter int SIGMOID_TABLE_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // in_blue, in_green, in_red, pixel_row, pixel_col
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // out_blue, out_green, out_red
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [12:0] cfg_data
);

	localparam int DW = $clog2(MAX_DIMENSION) + 1;
	localparam int IW = $clog2(SIGMOID_TABLE_DEPTH);
	localparam int PW = 24 + IW + 1;
	localparam int QW = PW - 16;
	localparam int RW = QW + 21;
	localparam int XW = QW - 7;
	localparam longint unsigned Q31 = 64'd1 << 31;

	typedef logic [7:0] sig_rom_t [SIGMOID_TABLE_DEPTH];

	// Shift-and-subtract quotient, used only while building the ROM
	function automatic longint unsigned udiv64(input longint unsigned num,
			input longint unsigned den);
		longint unsigned quo, rem;
		quo = '0;
		rem = '0;
		for (int k = 63; k >= 0; k--) begin
			rem = {rem[62:0], num[k]};
			if (rem >= den) begin
				rem = rem - den;
				quo[k] = 1'b1;
			end
		end
		return quo;
	endfunction

	function automatic sig_rom_t build_sig_rom();
		sig_rom_t rom;
		longint m;
		logic neg;
		longint unsigned u, term, pos, sub, e;
		for (int i = 0; i < SIGMOID_TABLE_DEPTH; i++) begin
			m = 16 * longint'(i) - 8 * longint'(SIGMOID_TABLE_DEPTH);
			neg = (m < 0);
			if (neg)
				m = -m;
			u = udiv64($unsigned(m) << 31, 64'(16 * SIGMOID_TABLE_DEPTH));
			term = Q31;
			pos = Q31;
			sub = 0;
			for (int n = 1; n <= 20; n++) begin
				term = udiv64((term * u) >> 31, 64'(n));
				if ((n & 1) != 0)
					sub = sub + term;
				else
					pos = pos + term;
			end
			e = (pos > sub) ? pos - sub : 64'd0;
			if (e > Q31)
				e = Q31;
			for (int n = 0; n < 4; n++)
				e = (e * e) >> 31;
			if (neg)
				rom[i] = 8'(udiv64(64'd255 * e, Q31 + e));
			else
				rom[i] = 8'(udiv64(64'd255 * Q31, Q31 + e));
		end
		return rom;
	endfunction

	localparam sig_rom_t SIG_ROM = build_sig_rom();

	// Configuration registers
	logic [7:0]    strength_q;
	logic [9:0]    cell_w_q;
	logic [8:0]    radius_q;
	logic [DW-1:0] rows_q;
	logic [DW-1:0] cols_q;

	function automatic logic [DW-1:0] sat_dim(input logic [12:0] v);
		if (32'(v) > MAX_DIMENSION)
			return DW'(MAX_DIMENSION);
		return DW'(v);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strength_q <= '0;
			cell_w_q   <= '0;
			radius_q   <= '0;
			rows_q     <= sat_dim(13'd4096);
			cols_q     <= sat_dim(13'd4096);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_STRENGTH: strength_q <= cfg_data[7:0];
				REG_CELL_W:   cell_w_q   <= cfg_data[9:0];
				REG_RADIUS:   radius_q   <= cfg_data[8:0];
				REG_ROWS:     rows_q     <= sat_dim(cfg_data);
				REG_COLS:     cols_q     <= sat_dim(cfg_data);
				default: ;
			endcase
		end
	end

	logic [7:0] alpha;
	assign alpha = 8'd255 - strength_q;

	// Flow control: a stage takes a new beat when it is empty or its contents move on
	logic [8:1] v_q;
	logic [9:1] en;

	always_comb begin
		en[9] = m_axis_tready;
		for (int k = 8; k >= 1; k--)
			en[k] = !v_q[k] || en[k+1];
	end

	assign s_axis_tready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[1])
				v_q[1] <= s_axis_tvalid;
			for (int k = 2; k <= 8; k++)
				if (en[k])
					v_q[k] <= v_q[k-1];
		end
	end

	logic [7:0] in_pix [3];
	assign in_pix[0] = s_axis_tdata[7:0];
	assign in_pix[1] = s_axis_tdata[15:8];
	assign in_pix[2] = s_axis_tdata[23:16];

	// Stage 1: weighted sums
	logic [7:0]         pix_s1 [3];
	logic [11:0]        row_s1, col_s1;
	logic signed [26:0] sum_s1 [3];

	always_ff @(posedge clk) begin
		if (en[1] && s_axis_tvalid) begin
			for (int c = 0; c < 3; c++) begin
				pix_s1[c] <= in_pix[c];
				sum_s1[c] <= 27'(COEF[c][0]) * 27'sd255
					+ 27'(COEF[c][1]) * 27'($signed({1'b0, in_pix[0]}))
					+ 27'(COEF[c][2]) * 27'($signed({1'b0, in_pix[1]}))
					+ 27'(COEF[c][3]) * 27'($signed({1'b0, in_pix[2]}));
			end
			row_s1 <= s_axis_tdata[35:24];
			col_s1 <= s_axis_tdata[47:36];
		end
	end

	// Stage 2: clamp and scale to table depth, first remainder digits
	logic [7:0]    pix_s2 [3];
	logic [QW-1:0] q_s2 [3];
	logic [2:0]    lo_s2, hi_s2;
	logic [11:0]   row_s2, col_s2;
	logic [9:0]    rrem_s2, crem_s2;
	logic [PW-1:0] scaled [3];

	always_comb begin
		for (int c = 0; c < 3; c++)
			scaled[c] = PW'(24'($unsigned(sum_s1[c] + 27'(SUM_LIMIT))))
				* PW'(SIGMOID_TABLE_DEPTH);
	end

	always_ff @(posedge clk) begin
		if (en[2] && v_q[1]) begin
			for (int c = 0; c < 3; c++) begin
				pix_s2[c] <= pix_s1[c];
				q_s2[c]   <= scaled[c][PW-1:16];
				lo_s2[c]  <= sum_s1[c] < -27'(SUM_LIMIT);
				hi_s2[c]  <= sum_s1[c] >= 27'(SUM_LIMIT);
			end
			row_s2  <= row_s1;
			col_s2  <= col_s1;
			rrem_s2 <= rem_step3(10'd0, row_s1[11:9], cell_w_q);
			crem_s2 <= rem_step3(10'd0, col_s1[11:9], cell_w_q);
		end
	end

	// Stage 3: table index by reciprocal of 255
	logic [7:0]    pix_s3 [3];
	logic [IW-1:0] idx_s3 [3];
	logic [11:0]   row_s3, col_s3;
	logic [9:0]    rrem_s3, crem_s3;
	logic [RW-1:0] rprod [3];
	logic [XW-1:0] idx_full [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			rprod[c]    = RW'(q_s2[c]) * RW'(RECIP_255);
			idx_full[c] = rprod[c][RECIP_SHIFT +: XW];
		end
	end

	always_ff @(posedge clk) begin
		if (en[3] && v_q[2]) begin
			for (int c = 0; c < 3; c++) begin
				pix_s3[c] <= pix_s2[c];
				if (lo_s2[c])
					idx_s3[c] <= '0;
				else if (hi_s2[c] || 32'(idx_full[c]) >= SIGMOID_TABLE_DEPTH)
					idx_s3[c] <= IW'(SIGMOID_TABLE_DEPTH - 1);
				else
					idx_s3[c] <= IW'(idx_full[c]);
			end
			row_s3  <= row_s2;
			col_s3  <= col_s2;
			rrem_s3 <= rem_step3(rrem_s2, row_s2[8:6], cell_w_q);
			crem_s3 <= rem_step3(crem_s2, col_s2[8:6], cell_w_q);
		end
	end

	// Stage 4: sigmoid lookup
	logic [7:0]  pix_s4 [3];
	logic [7:0]  sig_s4 [3];
	logic [11:0] row_s4, col_s4;
	logic [9:0]  rrem_s4, crem_s4;

	always_ff @(posedge clk) begin
		if (en[4] && v_q[3]) begin
			for (int c = 0; c < 3; c++) begin
				pix_s4[c] <= pix_s3[c];
				sig_s4[c] <= SIG_ROM[idx_s3[c]];
			end
			row_s4  <= row_s3;
			col_s4  <= col_s3;
			rrem_s4 <= rem_step3(rrem_s3, row_s3[5:3], cell_w_q);
			crem_s4 <= rem_step3(crem_s3, col_s3[5:3], cell_w_q);
		end
	end

	// Stage 5: blend products, last remainder digits
	logic [15:0] pa_s5 [3];
	logic [15:0] pb_s5 [3];
	logic [11:0] row_s5, col_s5;
	logic [9:0]  rrem_s5, crem_s5;

	always_ff @(posedge clk) begin
		if (en[5] && v_q[4]) begin
			for (int c = 0; c < 3; c++) begin
				pa_s5[c] <= 16'(pix_s4[c]) * 16'(alpha);
				pb_s5[c] <= 16'(sig_s4[c]) * 16'(strength_q);
			end
			row_s5  <= row_s4;
			col_s5  <= col_s4;
			rrem_s5 <= rem_step3(rrem_s4, row_s4[2:0], cell_w_q);
			crem_s5 <= rem_step3(crem_s4, col_s4[2:0], cell_w_q);
		end
	end

	// Stage 6: colour-mapped pixel, cell geometry
	logic [7:0]         n1_s6 [3];
	logic signed [11:0] dx_s6, dy_s6;
	logic               ok_s6;
	logic [15:0]        rbase, cbase, ri0, ci0, half, wid, rad, nrows, ncols;
	logic               fit;

	always_comb begin
		half  = 16'(cell_w_q >> 1);
		wid   = 16'(cell_w_q);
		rad   = 16'(radius_q);
		nrows = 16'(rows_q);
		ncols = 16'(cols_q);
		rbase = 16'(row_s5) - 16'(rrem_s5);
		cbase = 16'(col_s5) - 16'(crem_s5);
		ri0   = rbase + half;
		ci0   = cbase + half;
		fit   = (cell_w_q != '0) && (radius_q != '0)
			&& (rbase + wid <= nrows) && (cbase + wid <= ncols)
			&& (ri0 + rad + 16'd1 <= nrows) && (ci0 + rad + 16'd1 <= ncols)
			&& (ri0 >= rad) && (ci0 >= rad);
	end

	always_ff @(posedge clk) begin
		if (en[6] && v_q[5]) begin
			for (int c = 0; c < 3; c++)
				n1_s6[c] <= div255(pa_s5[c]) + div255(pb_s5[c]);
			dx_s6 <= $signed({2'b00, rrem_s5}) - $signed(12'(half));
			dy_s6 <= $signed({2'b00, crem_s5}) - $signed(12'(half));
			ok_s6 <= fit;
		end
	end

	// Stage 7: distance squared, dot blend products
	logic [7:0]         n1_s7 [3];
	logic [15:0]        qa_s7 [3];
	logic [15:0]        qb_s7 [3];
	logic [21:0]        dist_s7;
	logic               ok_s7;
	logic signed [23:0] dxx, dyy;

	assign dxx = dx_s6 * dx_s6;
	assign dyy = dy_s6 * dy_s6;

	always_ff @(posedge clk) begin
		if (en[7] && v_q[6]) begin
			for (int c = 0; c < 3; c++) begin
				n1_s7[c] <= n1_s6[c];
				qa_s7[c] <= 16'(n1_s6[c]) * 16'(alpha);
				qb_s7[c] <= 16'(DOT_COLOUR[c]) * 16'(strength_q);
			end
			dist_s7 <= 22'(dxx) + 22'(dyy);
			ok_s7   <= ok_s6;
		end
	end

	// Stage 8: output register
	logic [7:0]  out_s8 [3];
	logic [21:0] rsq;
	logic        hit;

	assign rsq = 22'(radius_q) * 22'(radius_q);
	assign hit = ok_s7 && (dist_s7 <= rsq);

	always_ff @(posedge clk) begin
		if (en[8] && v_q[7]) begin
			for (int c = 0; c < 3; c++)
				out_s8[c] <= hit ? div255(qa_s7[c]) + div255(qb_s7[c]) : n1_s7[c];
		end
	end

	assign m_axis_tvalid = v_q[8];
	assign m_axis_tdata  = {out_s8[2], out_s8[1], out_s8[0]};

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> v_q[1])
		else $error("accepted beat did not enter stage 1");

	a_hit_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[7] && hit |-> cell_w_q != '0 && radius_q != '0)
		else $error("dot applied with circles disabled");

	a_held_stall: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[8] && !m_axis_tready |=> v_q[8] && $stable(m_axis_tdata))
		else $error("output stage overwritten while stalled");

endmodule
